>>> design/npst_pkg.sv
// Package for the neighbor phase sync timer.
// Holds widths, reset values, register indexes and the control enums.
// No dependencies.
package npst_pkg;

  localparam int ACCUM_BITS = 24;
  localparam int CNT_W = $clog2(ACCUM_BITS);

  localparam logic [7:0] PERIOD_RST = 8'd50;
  localparam logic [9:0] DIVIDER_RST = 10'd120;
  localparam logic [6:0] CAP_RST = 7'd30;
  localparam logic [7:0] TX_LIMIT = 8'd255;

  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DIVIDER = 2'd1;
  localparam logic [1:0] CFG_CAP = 2'd2;

  localparam logic MODE_TICK = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_ADD,
    FIN_MOD,
    FIN_FIRE
  } fin_t;

endpackage

>>> design/neighbor_phase_sync_timer.sv
// Top level of the neighbor phase sync timer: control, serial divider and state.
// Depends on npst_pkg.
//
// channel  direction  handshake            payload
// s        in         s_tvalid / s_tready  s_tdata, s_tuser
// m        out        m_tvalid / m_tready  m_tdata
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A result is registered at the output after the prepare and finish states when no division
// is needed, and after the restoring divider has also run its 24 one-bit steps (a
// firing tick, or a message whose discrepancy needs a remainder by the period). The next
// item is accepted back in the idle state, so items do not overlap.
// The synchronous reset clears the control and timer state and loads the configuration defaults.
// A full output register stalls only the final step; a new item is taken once the
// previous one has reached the output register.
module neighbor_phase_sync_timer
  import npst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // neighbor_count
  input  logic       s_tuser,   // mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [15:0] m_tdata,  // fired, led_on, tx_valid, tx_count[7:0], zero fill
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  state_t state, state_next;
  fin_t fin;

  logic [7:0] period;
  logic [9:0] divider;
  logic [6:0] cap;

  logic mode_r;
  logic [7:0] nb_r;
  logic [15:0] elapsed;
  logic [8:0] interval;
  logic signed [ACCUM_BITS-1:0] accum;
  logic led;

  logic neg;
  logic signed [9:0] fold;
  logic [ACCUM_BITS-1:0] dq;
  logic [9:0] drem;
  logic [9:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic signed [16:0] d;
  logic [15:0] mag;
  logic [6:0] half;
  logic [15:0] elapsed_inc;
  logic fire_now;
  logic prep_div;
  logic signed [9:0] prep_fold;
  logic [ACCUM_BITS-1:0] accum_mag;
  logic [10:0] trial;
  logic [10:0] shifted;
  logic signed [10:0] addend;
  logic signed [ACCUM_BITS:0] sum;
  logic signed [ACCUM_BITS-1:0] sum_sat;
  logic [6:0] qc;
  logic signed [9:0] iv;
  logic fin_go;
  logic [15:0] elapsed_post;
  logic led_post;
  logic tx_ok;

  localparam logic signed [ACCUM_BITS:0] ACC_MAX = (ACCUM_BITS+1)'((1 << (ACCUM_BITS-1)) - 1);
  localparam logic signed [ACCUM_BITS:0] ACC_MIN = -ACC_MAX - (ACCUM_BITS+1)'(1);

  always_comb begin
    d = $signed({1'b0, elapsed}) - $signed({9'b0, nb_r});
    mag = d[16] ? 16'(-d) : d[15:0];
    half = period[7:1];
    elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
    fire_now = elapsed_inc >= {7'b0, interval};
    accum_mag = accum[ACCUM_BITS-1] ? ACCUM_BITS'(-accum) : accum;
    prep_div = 1'b0;
    prep_fold = '0;
    if (d == 17'sd0) begin
      prep_fold = '0;
    end else if (mag < {9'b0, half}) begin
      prep_fold = d[9:0];
    end else if (period == 8'd0) begin
      prep_fold = '0;
    end else if (!d[16] && mag < {8'b0, period}) begin
      prep_fold = $signed(d[9:0]) - $signed({2'b0, period});
    end else if (d[16] && mag <= {8'b0, period}) begin
      prep_fold = $signed(d[9:0]) + $signed({2'b0, period});
    end else begin
      prep_div = 1'b1;
    end
    trial = {drem, dq[ACCUM_BITS-1]} - {1'b0, dvs};
    shifted = {drem, dq[ACCUM_BITS-1]};
    addend = (fin == FIN_MOD) ? (neg ? -$signed({1'b0, drem}) : $signed({1'b0, drem}))
                              : 11'(fold);
    sum = $signed({accum[ACCUM_BITS-1], accum}) + (ACCUM_BITS+1)'(addend);
    if (sum > ACC_MAX) begin
      sum_sat = ACC_MAX[ACCUM_BITS-1:0];
    end else if (sum < ACC_MIN) begin
      sum_sat = ACC_MIN[ACCUM_BITS-1:0];
    end else begin
      sum_sat = sum[ACCUM_BITS-1:0];
    end
    qc = (dq > ACCUM_BITS'(cap)) ? cap : dq[6:0];
    iv = neg ? $signed({2'b0, period}) - $signed({3'b0, qc})
             : $signed({2'b0, period}) + $signed({3'b0, qc});
    elapsed_post = (fin == FIN_FIRE) ? 16'd0 : elapsed;
    led_post = (fin == FIN_FIRE) ? 1'b1 : led;
    tx_ok = elapsed_post < {8'b0, TX_LIMIT};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (mode_r == MODE_TICK) begin
          state_next = fire_now ? ST_DIV : ST_FINISH;
        end else begin
          state_next = prep_div ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    cfg_ready = 1'b1;
    fin_go = (state == ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      period <= PERIOD_RST;
      divider <= DIVIDER_RST;
      cap <= CAP_RST;
      elapsed <= '0;
      interval <= '0;
      accum <= '0;
      led <= 1'b0;
      m_tvalid <= 1'b0;
      fin <= FIN_NONE;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PERIOD: period <= cfg_data[7:0];
          CFG_DIVIDER: divider <= cfg_data;
          CFG_CAP: cap <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode_r <= s_tuser;
            nb_r <= s_tdata;
          end
        end
        ST_PREP: begin
          drem <= '0;
          cnt <= CNT_W'(ACCUM_BITS - 1);
          if (mode_r == MODE_TICK) begin
            elapsed <= elapsed_inc;
            if (fire_now) begin
              dq <= accum_mag;
              dvs <= (divider == 10'd0) ? 10'd1 : divider;
              neg <= accum[ACCUM_BITS-1];
              fin <= FIN_FIRE;
            end else begin
              if (elapsed_inc > 16'd1) begin
                led <= 1'b0;
              end
              fin <= FIN_NONE;
            end
          end else begin
            fold <= prep_fold;
            dq <= ACCUM_BITS'(mag);
            dvs <= {2'b0, period};
            neg <= d[16];
            fin <= prep_div ? FIN_MOD : FIN_ADD;
          end
        end
        ST_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (!trial[10]) begin
            drem <= trial[9:0];
            dq <= {dq[ACCUM_BITS-2:0], 1'b1};
          end else begin
            drem <= shifted[9:0];
            dq <= {dq[ACCUM_BITS-2:0], 1'b0};
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            case (fin) inside
              FIN_ADD, FIN_MOD: accum <= sum_sat;
              FIN_FIRE: begin
                interval <= iv[9] ? 9'd0 : iv[8:0];
                elapsed <= '0;
                accum <= '0;
                led <= 1'b1;
              end
              default: ;
            endcase
            m_tdata <= {5'b0, tx_ok ? elapsed_post[7:0] : 8'd0, tx_ok, led_post,
                        fin == FIN_FIRE};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
